[design/obb_sphere_overlap_test_core_assert.svh]
// Assertion macros for the oriented box / sphere overlap core.
// No dependencies; the including module supplies clk and rst_n.
`ifndef OBB_SPHERE_OVERLAP_TEST_CORE_ASSERT_SVH
`define OBB_SPHERE_OVERLAP_TEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define OBST_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obst check failed");
// Next-cycle implication, checked outside reset.
`define OBST_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obst check failed");
`else
`define OBST_CHECK_NOW(lbl, ante, cons)
`define OBST_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

[design/obst_pkg.sv]
// Shared types, widths and register indexes for the box / sphere overlap core.
// No dependencies.
package obst_pkg;

    localparam int NSTAGE = 8;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_Z  = 3'd2;
    localparam logic [2:0] REG_AXIS_A    = 3'd3;
    localparam logic [2:0] REG_AXIS_B    = 3'd4;
    localparam logic [2:0] REG_AXIS_C    = 3'd5;
    localparam logic [2:0] REG_HALF      = 3'd6;

    localparam logic [47:0] AXIS_A_RESET = 48'h0000_0000_4000;
    localparam logic [47:0] AXIS_B_RESET = 48'h0000_4000_0000;
    localparam logic [47:0] AXIS_C_RESET = 48'h4000_0000_0000;

    // Datapath widths (fraction bits in comments)
    localparam int DELTA_W = 25;   // Q.8
    localparam int DOT_W   = 41;   // Q.22
    localparam int SUM_W   = 43;   // Q.22
    localparam int PROJ_W  = 36;   // Q.22 after clamp
    localparam int REB_W   = 52;   // Q.36
    localparam int OFF_W   = 54;   // Q.36
    localparam int OFF8_W  = 26;   // Q.8
    localparam int D_W     = 28;   // Q.8
    localparam int SQ_W    = 55;   // Q.16
    localparam int DIST_W  = 57;   // Q.16
    localparam int R2_W    = 46;   // Q.16

    typedef logic [2:0][23:0] vec3_t;     // x in [0]
    typedef logic [2:0][15:0] axis_t;     // Q1.14 components, x in [0]
    typedef logic [2:0][20:0] half_t;     // Q13.8 half sizes

    typedef logic signed [PROJ_W-1:0] proj_t;
    typedef logic signed [D_W-1:0]    dist_t;

    typedef struct packed {
        logic [15:0] index;
        logic        last;
    } tag_t;

    typedef struct packed {
        logic [NSTAGE-1:0] valid;
        logic [NSTAGE-1:0] en;
    } pipe_ctl_t;

endpackage

[design/obst_ctrl.sv]
// Valid chain and per-stage load enables for the overlap pipeline.
// Depends on obst_pkg.
module obst_ctrl
    import obst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_ready,
    output pipe_ctl_t ctl
);

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] en;

    // A stage loads when it is empty or its content moves on
    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.en    = en;

endmodule

[design/obst_project.sv]
// Stages 1-3: offset from box center, dot products with the axes, clamp.
// Depends on obst_pkg.
module obst_project
    import obst_pkg::*;
(
    input  logic        clk,
    input  logic [2:0]  en,
    input  vec3_t       sphere,
    input  logic [22:0] radius,
    input  tag_t        tag_in,
    input  vec3_t       center,
    input  axis_t       axis [3],
    input  half_t       half,
    output proj_t       proj [3],
    output vec3_t       sp_out,
    output logic [R2_W-1:0] r2_out,
    output tag_t        tag_out
);

    logic signed [DELTA_W-1:0] delta_reg [3];
    logic signed [DELTA_W-1:0] delta_next [3];
    logic signed [DOT_W-1:0]   dot_reg [3][3];
    logic signed [DOT_W-1:0]   dot_next [3][3];
    proj_t                     proj_reg [3];
    proj_t                     proj_next [3];

    vec3_t           sp1_reg, sp2_reg, sp3_reg;
    logic [R2_W-1:0] r2_1_reg, r2_2_reg, r2_3_reg;
    logic [R2_W-1:0] r2_next;
    tag_t            tag1_reg, tag2_reg, tag3_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            delta_next[k] = $signed({sphere[k][23], sphere[k]})
                          - $signed({center[k][23], center[k]});
        end
        r2_next = {23'd0, radius} * {23'd0, radius};
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dot_next[i][k] = DOT_W'(delta_reg[k]) * DOT_W'($signed(axis[i][k]));
            end
        end
    end

    // Clamp each projection to the half size, moved to Q.22
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] lim;
        logic signed [SUM_W-1:0] clamped;
        for (int i = 0; i < 3; i++)
        begin
            sum = SUM_W'(dot_reg[i][0]) + SUM_W'(dot_reg[i][1]) + SUM_W'(dot_reg[i][2]);
            lim = $signed({8'd0, half[i], 14'd0});
            if (sum > lim)
            begin
                clamped = lim;
            end
            else if (sum < -lim)
            begin
                clamped = -lim;
            end
            else
            begin
                clamped = sum;
            end
            proj_next[i] = clamped[PROJ_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            delta_reg <= delta_next;
            sp1_reg   <= sphere;
            r2_1_reg  <= r2_next;
            tag1_reg  <= tag_in;
        end
        if (en[1])
        begin
            dot_reg  <= dot_next;
            sp2_reg  <= sp1_reg;
            r2_2_reg <= r2_1_reg;
            tag2_reg <= tag1_reg;
        end
        if (en[2])
        begin
            proj_reg <= proj_next;
            sp3_reg  <= sp2_reg;
            r2_3_reg <= r2_2_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign proj    = proj_reg;
    assign sp_out  = sp3_reg;
    assign r2_out  = r2_3_reg;
    assign tag_out = tag3_reg;

endmodule

[design/obst_rebuild.sv]
// Stages 4-6: rebuild the closest box point and its offset to the sphere.
// Depends on obst_pkg.
module obst_rebuild
    import obst_pkg::*;
(
    input  logic            clk,
    input  logic [2:0]      en,
    input  proj_t           proj [3],
    input  vec3_t           sp_in,
    input  logic [R2_W-1:0] r2_in,
    input  tag_t            tag_in,
    input  vec3_t           center,
    input  axis_t           axis [3],
    output dist_t           d_out [3],
    output logic [R2_W-1:0] r2_out,
    output tag_t            tag_out
);

    logic signed [REB_W-1:0]  reb_reg [3][3];
    logic signed [REB_W-1:0]  reb_next [3][3];
    logic signed [OFF8_W-1:0] off8_reg [3];
    logic signed [OFF8_W-1:0] off8_next [3];
    dist_t                    d_reg [3];
    dist_t                    d_next [3];

    vec3_t           sp4_reg, sp5_reg;
    logic [R2_W-1:0] r2_4_reg, r2_5_reg, r2_6_reg;
    tag_t            tag4_reg, tag5_reg, tag6_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                reb_next[i][k] = REB_W'(proj[i]) * REB_W'($signed(axis[i][k]));
            end
        end
    end

    // Sum over the axes, round half up from Q.36 to Q.8
    always_comb
    begin
        logic signed [OFF_W-1:0] off;
        for (int k = 0; k < 3; k++)
        begin
            off = OFF_W'(reb_reg[0][k]) + OFF_W'(reb_reg[1][k]) + OFF_W'(reb_reg[2][k])
                + $signed({{(OFF_W-28){1'b0}}, 1'b1, 27'd0});
            off8_next[k] = off[OFF_W-1:28];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = D_W'($signed(center[k])) + D_W'(off8_reg[k])
                      - D_W'($signed(sp5_reg[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            reb_reg  <= reb_next;
            sp4_reg  <= sp_in;
            r2_4_reg <= r2_in;
            tag4_reg <= tag_in;
        end
        if (en[1])
        begin
            off8_reg <= off8_next;
            sp5_reg  <= sp4_reg;
            r2_5_reg <= r2_4_reg;
            tag5_reg <= tag4_reg;
        end
        if (en[2])
        begin
            d_reg    <= d_next;
            r2_6_reg <= r2_5_reg;
            tag6_reg <= tag5_reg;
        end
    end

    assign d_out   = d_reg;
    assign r2_out  = r2_6_reg;
    assign tag_out = tag6_reg;

endmodule

[design/obst_compare.sv]
// Stages 7-8: squared distance against squared radius.
// Depends on obst_pkg.
module obst_compare
    import obst_pkg::*;
(
    input  logic            clk,
    input  logic [1:0]      en,
    input  dist_t           d_in [3],
    input  logic [R2_W-1:0] r2_in,
    input  tag_t            tag_in,
    output logic            hit,
    output tag_t            tag_out
);

    logic [SQ_W-1:0] sq_reg [3];
    logic [SQ_W-1:0] sq_next [3];
    logic [R2_W-1:0] r2_7_reg;
    tag_t            tag7_reg, tag8_reg;
    logic            hit_reg;
    logic            hit_next;

    always_comb
    begin
        logic signed [2*D_W-1:0] prod;
        for (int k = 0; k < 3; k++)
        begin
            prod       = $signed({{D_W{d_in[k][D_W-1]}}, d_in[k]})
                       * $signed({{D_W{d_in[k][D_W-1]}}, d_in[k]});
            sq_next[k] = prod[SQ_W-1:0];
        end
    end

    always_comb
    begin
        logic [DIST_W-1:0] dist2;
        dist2 = {2'd0, sq_reg[0]} + {2'd0, sq_reg[1]} + {2'd0, sq_reg[2]};
        hit_next = dist2 < {{(DIST_W-R2_W){1'b0}}, r2_7_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sq_reg   <= sq_next;
            r2_7_reg <= r2_in;
            tag7_reg <= tag_in;
        end
        if (en[1])
        begin
            hit_reg  <= hit_next;
            tag8_reg <= tag7_reg;
        end
    end

    assign hit     = hit_reg;
    assign tag_out = tag8_reg;

endmodule

[design/obb_sphere_overlap_test_core.sv]
// Oriented box / sphere overlap tester. One box (center, three Q1.14 axes,
// three Q13.8 half sizes) sits in configuration registers; each sphere item
// on the slave stream gets one result item on the master stream: hit is set
// when the squared distance from the closest box point to the sphere center
// is strictly below the squared radius. The pipeline has eight register
// stages, and a new sphere can be taken every cycle unless a stalled output
// backs the pipeline up. The last stage is the output register; empty
// stages fill while the output waits, so up to eight items are held before
// s_tready drops. Write configuration only while the pipeline is empty.
`include "obb_sphere_overlap_test_core_assert.svh"

module obb_sphere_overlap_test_core
    import obst_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [62:0]  cfg_data,
    // sphere items
    input  logic         s_tvalid,
    output logic         s_tready,
    // sphere_x[23:0], sphere_y[47:24], sphere_z[71:48], sphere_radius[94:72],
    // item_index[110:95], zero pad [111]
    input  logic [111:0] s_tdata,
    input  logic         s_tlast,      // last_item
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit[0], hit_index[16:1], zero pad [23:17]
    output logic [23:0]  m_tdata,
    output logic         m_tlast       // batch_end
);

    // Box registers
    vec3_t center_reg;
    axis_t axis_reg [3];
    half_t half_reg;

    pipe_ctl_t ctl;

    proj_t           proj [3];
    vec3_t           sp3;
    logic [R2_W-1:0] r2_3;
    tag_t            tag3;
    dist_t           d6 [3];
    logic [R2_W-1:0] r2_6;
    tag_t            tag6;
    logic            hit;
    tag_t            tag8;
    tag_t            tag_in;

    // Handshakes and stage occupancy, watched by the checks below
    logic            in_fire;
    logic            out_fire;
    logic [3:0]      occupancy;

    // Drop writes to indexes past the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= '0;
            axis_reg[0] <= AXIS_A_RESET;
            axis_reg[1] <= AXIS_B_RESET;
            axis_reg[2] <= AXIS_C_RESET;
            half_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X: center_reg[0] <= cfg_data[23:0];
                REG_CENTER_Y: center_reg[1] <= cfg_data[23:0];
                REG_CENTER_Z: center_reg[2] <= cfg_data[23:0];
                REG_AXIS_A:   axis_reg[0]   <= cfg_data[47:0];
                REG_AXIS_B:   axis_reg[1]   <= cfg_data[47:0];
                REG_AXIS_C:   axis_reg[2]   <= cfg_data[47:0];
                REG_HALF:     half_reg      <= cfg_data[62:0];
                default:      ;
            endcase
        end
    end

    obst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    assign tag_in.index = s_tdata[110:95];
    assign tag_in.last  = s_tlast;

    obst_project u_project (
        .clk     (clk),
        .en      (ctl.en[2:0]),
        .sphere  (s_tdata[71:0]),
        .radius  (s_tdata[94:72]),
        .tag_in  (tag_in),
        .center  (center_reg),
        .axis    (axis_reg),
        .half    (half_reg),
        .proj    (proj),
        .sp_out  (sp3),
        .r2_out  (r2_3),
        .tag_out (tag3)
    );

    obst_rebuild u_rebuild (
        .clk     (clk),
        .en      (ctl.en[5:3]),
        .proj    (proj),
        .sp_in   (sp3),
        .r2_in   (r2_3),
        .tag_in  (tag3),
        .center  (center_reg),
        .axis    (axis_reg),
        .d_out   (d6),
        .r2_out  (r2_6),
        .tag_out (tag6)
    );

    obst_compare u_compare (
        .clk     (clk),
        .en      (ctl.en[7:6]),
        .d_in    (d6),
        .r2_in   (r2_6),
        .tag_in  (tag6),
        .hit     (hit),
        .tag_out (tag8)
    );

    // Hold the handshake on the valid chain
    assign s_tready = ctl.en[0];
    assign m_tvalid = ctl.valid[NSTAGE-1];
    assign m_tdata  = {7'd0, tag8.index, hit};
    assign m_tlast  = tag8.last;

    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign occupancy = 4'($countones(ctl.valid));

    // Any empty stage lets a new item in
    `OBST_CHECK_NOW(a_accept_when_room, (ctl.valid != '1), s_tready)
    // Items in flight grow by one on an input-only cycle
    `OBST_CHECK_NEXT(a_count_up, (in_fire && !out_fire), (occupancy == $past(occupancy) + 4'd1))
    // Items in flight shrink by one on an output-only cycle
    `OBST_CHECK_NEXT(a_count_down, (!in_fire && out_fire), (occupancy + 4'd1 == $past(occupancy)))

endmodule
